// ===== rtl/mrs_pkg.sv =====
// Shared types, message codes and a decode function for the MIDI running-status parser.
package mrs_pkg;

   // Result kinds
   localparam logic [2:0] MSG_NOTE_ON   = 3'd0;
   localparam logic [2:0] MSG_NOTE_OFF  = 3'd1;
   localparam logic [2:0] MSG_CTRL_CHG  = 3'd2;
   localparam logic [2:0] MSG_PITCH_BND = 3'd3;
   localparam logic [2:0] MSG_CHAN_PRS  = 3'd4;

   // Status command nibbles
   localparam logic [3:0] CMD_NOTE_OFF  = 4'h8;
   localparam logic [3:0] CMD_NOTE_ON   = 4'h9;
   localparam logic [3:0] CMD_POLY_PRS  = 4'hA;
   localparam logic [3:0] CMD_CTRL_CHG  = 4'hB;
   localparam logic [3:0] CMD_PROG_CHG  = 4'hC;
   localparam logic [3:0] CMD_CHAN_PRS  = 4'hD;
   localparam logic [3:0] CMD_PITCH_BND = 4'hE;
   localparam logic [3:0] CMD_SYSTEM    = 4'hF;

   // System common status bytes that carry data
   localparam logic [7:0] SYS_TIME_CODE = 8'hF1;
   localparam logic [7:0] SYS_SONG_POS  = 8'hF2;
   localparam logic [7:0] SYS_SONG_SEL  = 8'hF3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_packet;
   } req_type;

   typedef struct packed {
      logic [2:0]  msg_type;
      logic [7:0]  first_data;
      logic [7:0]  second_data;
      logic [14:0] bend_value;
   } rsp_type;

   // Number of data bytes that follow a status byte
   function automatic logic [1:0] data_len(input logic [7:0] st);
      logic [1:0] n;
      n = 2'd0;
      unique case (st[7:4]) inside
         CMD_PROG_CHG, CMD_CHAN_PRS: n = 2'd1;
         CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_PRS, CMD_CTRL_CHG, CMD_PITCH_BND: n = 2'd2;
         CMD_SYSTEM: begin
            unique case (st) inside
               SYS_TIME_CODE, SYS_SONG_SEL: n = 2'd1;
               SYS_SONG_POS:                n = 2'd2;
               default:                     n = 2'd0;
            endcase
         end
         default: n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/midi_running_status_parser.sv =====
// Top level: MIDI byte parser with running status and a registered result stage.
//
//  channel  dir  handshake             payload
//  req_     in   req_valid/req_stall   req_data (mrs_pkg::req_type)
//  rsp_     out  rsp_valid/rsp_stall   rsp_data (mrs_pkg::rsp_type)
//
// One byte is taken per cycle while req_stall is low; a result is registered with the byte that completes it.
// The parse state and the result register sit on either side of one shallow decode.
// Reset (synchronous) clears running status, the byte count and the result valid.
// req_stall rises only while a result is held and rsp_stall is high; a new byte is
// taken in the same cycle that the held result is transferred.
module midi_running_status_parser
   import mrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [7:0] status_ff, status_in;
   logic [1:0] need_ff, need_in;
   logic       seen_ff, seen_in;
   logic       drop_ff, drop_in;
   logic [7:0] held_ff, held_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       emit;
   logic       req_xfer;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;

   always_comb begin
      logic [7:0] b;
      logic [1:0] n;
      logic       fin;
      logic [7:0] d1;
      logic [7:0] d2;

      b         = req_data.data_byte;
      n         = 2'd0;
      fin       = 1'b0;
      d1        = 8'd0;
      d2        = 8'd0;
      status_in = status_ff;
      need_in   = need_ff;
      seen_in   = seen_ff;
      drop_in   = drop_ff;
      held_in   = held_ff;

      // a packet start drops running status and any partial message
      if (req_data.first_of_packet) begin
         status_in = 8'd0;
         need_in   = 2'd0;
         seen_in   = 1'b0;
         drop_in   = 1'b0;
      end

      if (!drop_in) begin
         if (need_in == 2'd0) begin
            if (b[7]) begin
               status_in = b;
               n         = data_len(b);
               if (n == 2'd0) begin
                  drop_in = 1'b1;
               end else begin
                  need_in = n;
                  seen_in = 1'b0;
               end
            end else if (status_in == 8'd0) begin
               drop_in = 1'b1;
            end else begin
               n = data_len(status_in);
               if (n == 2'd0) begin
                  drop_in = 1'b1;
               end else begin
                  held_in = b;
                  if (n == 2'd1) begin
                     fin = 1'b1;
                     d1  = b;
                  end else begin
                     need_in = n;
                     seen_in = 1'b1;
                  end
               end
            end
         end else if (!seen_in) begin
            held_in = b;
            if (need_in == 2'd1) begin
               fin = 1'b1;
               d1  = b;
            end else begin
               seen_in = 1'b1;
            end
         end else begin
            fin = 1'b1;
            d1  = held_ff;
            d2  = b;
         end
      end

      if (fin) begin
         need_in = 2'd0;
         seen_in = 1'b0;
      end

      // classify the completed message by its command nibble; a zero-velocity note on is a note off
      emit                    = 1'b0;
      rsp_data_in.msg_type    = MSG_NOTE_ON;
      rsp_data_in.first_data  = d1;
      rsp_data_in.second_data = d2;
      rsp_data_in.bend_value  = 15'd0;
      if (fin) begin
         emit = 1'b1;
         if (status_in[7:4] == CMD_NOTE_ON && d2 != 8'd0) begin
            rsp_data_in.msg_type = MSG_NOTE_ON;
         end else if (status_in[7:4] == CMD_NOTE_OFF || status_in[7:4] == CMD_NOTE_ON) begin
            rsp_data_in.msg_type = MSG_NOTE_OFF;
         end else if (status_in[7:4] == CMD_CTRL_CHG) begin
            rsp_data_in.msg_type = MSG_CTRL_CHG;
         end else if (status_in[7:4] == CMD_PITCH_BND) begin
            rsp_data_in.msg_type   = MSG_PITCH_BND;
            rsp_data_in.bend_value = {d2, 7'd0} | {7'd0, d1};
         end else if (status_in[7:4] == CMD_CHAN_PRS) begin
            rsp_data_in.msg_type    = MSG_CHAN_PRS;
            rsp_data_in.second_data = 8'd0;
         end else begin
            emit = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= 8'd0;
         need_ff      <= 2'd0;
         seen_ff      <= 1'b0;
         drop_ff      <= 1'b0;
         held_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            status_ff    <= status_in;
            need_ff      <= need_in;
            seen_ff      <= seen_in;
            drop_ff      <= drop_in;
            held_ff      <= held_in;
            rsp_valid_ff <= emit;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the result while stalled; load it with the byte that completes it
   always_ff @(posedge clock) begin
      if (req_xfer && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/mrs_checker.sv =====
// Port-level checks for the MIDI running-status parser, bound to the top level.
module mrs_checker
   import mrs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // input side backs up only behind a held, stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled transfer dropped or changed");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.msg_type == MSG_NOTE_ON || rsp_data.msg_type == MSG_NOTE_OFF ||
                     rsp_data.msg_type == MSG_CTRL_CHG || rsp_data.msg_type == MSG_PITCH_BND ||
                     rsp_data.msg_type == MSG_CHAN_PRS))
      else $error("unknown message kind");

   a_bend_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.msg_type != MSG_PITCH_BND) |-> (rsp_data.bend_value == 15'd0))
      else $error("bend value set on a non-bend message");

endmodule

bind midi_running_status_parser mrs_checker u_mrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
